FILE: rtl/dllc_pkg.sv
// Shared types and operation codes for the doubly linked list cursor block.
// No dependencies; imported by doubly_linked_list_cursor and tb_top.

package dllc_pkg;

   // operation codes carried in the func field
   localparam logic [3:0] FN_FIRST        = 4'd0;
   localparam logic [3:0] FN_NEXT         = 4'd1;
   localparam logic [3:0] FN_LAST         = 4'd2;
   localparam logic [3:0] FN_PREV         = 4'd3;
   localparam logic [3:0] FN_PUSH_FRONT   = 4'd4;
   localparam logic [3:0] FN_PUSH_BACK    = 4'd5;
   localparam logic [3:0] FN_PUSH_CURRENT = 4'd6;
   localparam logic [3:0] FN_POP_FRONT    = 4'd7;
   localparam logic [3:0] FN_POP_BACK     = 4'd8;
   localparam logic [3:0] FN_POP_CURRENT  = 4'd9;
   localparam logic [3:0] FN_CLEAN        = 4'd10;

   typedef struct packed {
      logic [3:0]  func;
      logic [31:0] data_in;
   } req_type;

   typedef struct packed {
      logic [31:0] data_out;
      logic        has_value;
      logic        pool_full;
      logic        list_empty;
   } rsp_type;

endpackage

FILE: rtl/doubly_linked_list_cursor.sv
// A request is accepted in ST_IDLE and passes through ST_RD, then ST_RD2 and/or ST_WR2
// where the operation needs them (next/prev reach the new node in ST_RD2; front pushes onto
// a non-empty list and pops with a predecessor use ST_WR2; pushes after the cursor or tail
// use ST_RD2 then ST_WR2), and ends in ST_DONE. One transaction at a time: the
// read-modify-write sequence over the link memories (one write port each) sets the pace, and
// req_stall stays high until the response is loaded into the output register.
// Reset is synchronous: the list is empty and the free chain is
// whole, with no memory sweep.

module doubly_linked_list_cursor
   import dllc_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   // Pointers carry one extra bit: the value DEPTH stands for null.
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = AW + 1;
   localparam logic [LW-1:0] NIL = LW'(DEPTH);

   typedef logic [LW-1:0] ptr_type;
   typedef logic [AW-1:0] idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,   // waiting for a request; first memory reads issued on accept
      ST_RD,     // first read data back; main update
      ST_RD2,    // second read data back
      ST_WR2,    // second write into a link memory
      ST_DONE    // result waits for the output register
   } state_type;

   function automatic logic is_node(input ptr_type p);
      return p < NIL;
   endfunction

   function automatic idx_type idx(input ptr_type p);
      return p[AW-1:0];
   endfunction

   // ---------------------------------------------------------------------
   // Node pool memories with registered read data.
   // The free chain is a stack of recycled nodes (linked through next_link)
   // sitting on top of the never-used nodes fresh_ff..DEPTH-1. Taking the
   // node at fresh_ff advances the watermark instead of reading a link, so
   // neither reset nor clean needs to sweep next_link.
   // ---------------------------------------------------------------------
   logic [DATA_WIDTH-1:0] node_data [DEPTH];
   ptr_type               next_link [DEPTH];
   ptr_type               prev_link [DEPTH];

   idx_type               ndat_ra, nxt_ra, prv_ra;
   logic [DATA_WIDTH-1:0] ndat_q;
   ptr_type               nxt_q, prv_q;

   logic                  ndat_we, nxt_we, prv_we;
   idx_type               ndat_wa, nxt_wa, prv_wa;
   logic [DATA_WIDTH-1:0] ndat_wd;
   ptr_type               nxt_wd, prv_wd;

   always_ff @(posedge clock) begin
      if (ndat_we) begin
         node_data[ndat_wa] <= ndat_wd;
      end
      ndat_q <= node_data[ndat_ra];
   end

   always_ff @(posedge clock) begin
      if (nxt_we) begin
         next_link[nxt_wa] <= nxt_wd;
      end
      nxt_q <= next_link[nxt_ra];
   end

   always_ff @(posedge clock) begin
      if (prv_we) begin
         prev_link[prv_wa] <= prv_wd;
      end
      prv_q <= prev_link[prv_ra];
   end

   // ---------------------------------------------------------------------
   // Control and list registers
   // ---------------------------------------------------------------------
   state_type             state_ff, state_in;
   logic [3:0]            op_ff, op_in;
   logic [DATA_WIDTH-1:0] din_ff, din_in;
   ptr_type               head_ff, head_in;
   ptr_type               tail_ff, tail_in;
   ptr_type               cur_ff, cur_in;
   ptr_type               free_ff, free_in;
   ptr_type               fresh_ff, fresh_in;
   ptr_type               count_ff, count_in;
   ptr_type               node_ff, node_in;     // node being pushed, popped or reached
   ptr_type               anchor_ff, anchor_in; // insert-after point for pushes
   logic                  wr2_prv_ff, wr2_prv_in;
   idx_type               wr2_addr_ff, wr2_addr_in;
   ptr_type               wr2_data_ff, wr2_data_in;
   logic [DATA_WIDTH-1:0] res_data_ff, res_data_in;
   logic                  res_has_ff, res_has_in;
   logic                  res_full_ff, res_full_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  req_fire;
   logic [63:0]           din_ext;
   logic [63:0]           dout_ext;
   ptr_type               pop_sel;
   ptr_type               tgt;
   ptr_type               prior, after;
   logic                  front;

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign din_ext   = {32'b0, req_item.data_in};
   assign dout_ext  = 64'(res_data_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      din_in      = din_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      cur_in      = cur_ff;
      free_in     = free_ff;
      fresh_in    = fresh_ff;
      count_in    = count_ff;
      node_in     = node_ff;
      anchor_in   = anchor_ff;
      wr2_prv_in  = wr2_prv_ff;
      wr2_addr_in = wr2_addr_ff;
      wr2_data_in = wr2_data_ff;
      res_data_in = res_data_ff;
      res_has_in  = res_has_ff;
      res_full_in = res_full_ff;
      rsp_in      = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      ndat_ra = '0;
      nxt_ra  = '0;
      prv_ra  = '0;
      ndat_we = 1'b0;
      nxt_we  = 1'b0;
      prv_we  = 1'b0;
      ndat_wa = '0;
      nxt_wa  = '0;
      prv_wa  = '0;
      ndat_wd = din_ff;
      nxt_wd  = NIL;
      prv_wd  = NIL;

      pop_sel = cur_ff;
      tgt     = NIL;
      prior   = prv_q;
      after   = nxt_q;
      front   = 1'b0;

      // response taken downstream
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            // issue the first reads straight from the request payload
            case (req_item.func)
               FN_FIRST:       ndat_ra = idx(head_ff);
               FN_LAST:        ndat_ra = idx(tail_ff);
               FN_POP_FRONT:   pop_sel = head_ff;
               FN_POP_BACK:    pop_sel = tail_ff;
               default:        pop_sel = cur_ff;
            endcase
            if (req_item.func == FN_NEXT || req_item.func == FN_PREV) begin
               nxt_ra = idx(cur_ff);
               prv_ra = idx(cur_ff);
            end else if (req_item.func == FN_PUSH_FRONT || req_item.func == FN_PUSH_BACK ||
                         req_item.func == FN_PUSH_CURRENT) begin
               nxt_ra = idx(free_ff);
            end else if (req_item.func == FN_POP_FRONT || req_item.func == FN_POP_BACK ||
                         req_item.func == FN_POP_CURRENT) begin
               ndat_ra = idx(pop_sel);
               nxt_ra  = idx(pop_sel);
               prv_ra  = idx(pop_sel);
            end
            if (req_fire) begin
               op_in       = req_item.func;
               din_in      = din_ext[DATA_WIDTH-1:0];
               anchor_in   = (req_item.func == FN_PUSH_BACK) ? tail_ff : cur_ff;
               node_in     = (req_item.func == FN_POP_FRONT || req_item.func == FN_POP_BACK ||
                              req_item.func == FN_POP_CURRENT) ? pop_sel : free_ff;
               res_data_in = '0;
               res_has_in  = 1'b0;
               res_full_in = 1'b0;
               state_in    = ST_RD;
            end
         end

         ST_RD: begin
            state_in = ST_DONE;
            case (op_ff)
               FN_FIRST, FN_LAST: begin
                  tgt = (op_ff == FN_FIRST) ? head_ff : tail_ff;
                  if (is_node(tgt)) begin
                     cur_in      = tgt;
                     res_has_in  = 1'b1;
                     res_data_in = ndat_q;
                  end
               end

               FN_NEXT, FN_PREV: begin
                  tgt = (op_ff == FN_NEXT) ? nxt_q : prv_q;
                  if (is_node(cur_ff) && is_node(tgt)) begin
                     node_in  = tgt;
                     ndat_ra  = idx(tgt);
                     state_in = ST_RD2;
                  end
               end

               FN_PUSH_FRONT, FN_PUSH_BACK, FN_PUSH_CURRENT: begin
                  if (!is_node(node_ff)) begin
                     // pool exhausted: transaction dropped, nothing moves
                     res_full_in = 1'b1;
                  end else begin
                     if (node_ff == fresh_ff) begin
                        free_in  = node_ff + LW'(1);
                        fresh_in = fresh_ff + LW'(1);
                     end else begin
                        free_in  = nxt_q;
                     end
                     count_in = count_ff + LW'(1);
                     ndat_we  = 1'b1;
                     ndat_wa  = idx(node_ff);
                     ndat_wd  = din_ff;
                     front    = (op_ff == FN_PUSH_FRONT) || !is_node(anchor_ff);
                     if (front) begin
                        nxt_we  = 1'b1;
                        nxt_wa  = idx(node_ff);
                        nxt_wd  = head_ff;
                        prv_we  = 1'b1;
                        prv_wa  = idx(node_ff);
                        prv_wd  = NIL;
                        head_in = node_ff;
                        if (!is_node(head_ff)) begin
                           tail_in = node_ff;
                        end else begin
                           wr2_prv_in  = 1'b1;
                           wr2_addr_in = idx(head_ff);
                           wr2_data_in = node_ff;
                           state_in    = ST_WR2;
                        end
                     end else begin
                        prv_we = 1'b1;
                        prv_wa = idx(node_ff);
                        prv_wd = anchor_ff;
                        nxt_ra = idx(anchor_ff);
                        if (op_ff == FN_PUSH_BACK) begin
                           cur_in = anchor_ff;
                        end
                        state_in = ST_RD2;
                     end
                  end
               end

               FN_POP_FRONT, FN_POP_BACK, FN_POP_CURRENT: begin
                  if (!is_node(node_ff)) begin
                     cur_in = NIL;
                  end else begin
                     res_has_in  = 1'b1;
                     res_data_in = ndat_q;
                     // removed node goes on top of the free stack
                     nxt_we  = 1'b1;
                     nxt_wa  = idx(node_ff);
                     nxt_wd  = free_ff;
                     free_in = node_ff;
                     if (count_ff != '0) begin
                        count_in = count_ff - LW'(1);
                     end
                     if (is_node(after)) begin
                        prv_we = 1'b1;
                        prv_wa = idx(after);
                        prv_wd = prior;
                     end else begin
                        tail_in = prior;
                     end
                     cur_in = after;
                     if (is_node(prior)) begin
                        wr2_prv_in  = 1'b0;
                        wr2_addr_in = idx(prior);
                        wr2_data_in = after;
                        state_in    = ST_WR2;
                     end else begin
                        head_in = after;
                     end
                  end
               end

               FN_CLEAN: begin
                  head_in  = NIL;
                  tail_in  = NIL;
                  cur_in   = NIL;
                  free_in  = '0;
                  fresh_in = '0;
                  count_in = '0;
               end

               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         ST_RD2: begin
            state_in = ST_DONE;
            case (op_ff)
               FN_NEXT, FN_PREV: begin
                  cur_in      = node_ff;
                  res_has_in  = 1'b1;
                  res_data_in = ndat_q;
               end

               FN_PUSH_BACK, FN_PUSH_CURRENT: begin
                  // nxt_q holds the anchor's old successor
                  nxt_we = 1'b1;
                  nxt_wa = idx(node_ff);
                  nxt_wd = after;
                  if (is_node(after)) begin
                     prv_we = 1'b1;
                     prv_wa = idx(after);
                     prv_wd = node_ff;
                  end else begin
                     tail_in = node_ff;
                  end
                  wr2_prv_in  = 1'b0;
                  wr2_addr_in = idx(anchor_ff);
                  wr2_data_in = node_ff;
                  state_in    = ST_WR2;
               end

               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         ST_WR2: begin
            if (wr2_prv_ff) begin
               prv_we = 1'b1;
               prv_wa = wr2_addr_ff;
               prv_wd = wr2_data_ff;
            end else begin
               nxt_we = 1'b1;
               nxt_wa = wr2_addr_ff;
               nxt_wd = wr2_data_ff;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.data_out   = res_has_ff ? dout_ext[31:0] : 32'd0;
               rsp_in.has_value  = res_has_ff;
               rsp_in.pool_full  = res_full_ff;
               rsp_in.list_empty = (count_ff == '0);
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= NIL;
         tail_ff      <= NIL;
         cur_ff       <= NIL;
         free_ff      <= '0;
         fresh_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cur_ff       <= cur_in;
         free_ff      <= free_in;
         fresh_ff     <= fresh_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      din_ff      <= din_in;
      node_ff     <= node_in;
      anchor_ff   <= anchor_in;
      wr2_prv_ff  <= wr2_prv_in;
      wr2_addr_ff <= wr2_addr_in;
      wr2_data_ff <= wr2_data_in;
      res_data_ff <= res_data_in;
      res_has_ff  <= res_has_in;
      res_full_ff <= res_full_in;
      rsp_ff      <= rsp_in;
   end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for doubly_linked_list_cursor: a directed table, then random
// operation mixes, checked against a predictor of the pool-based list and its cursor.
// Depends on dllc_pkg (operation codes, transaction types) and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
   import dllc_pkg::*;

   localparam int LIST_DEPTH   = 16;
   localparam int RANDOM_ITEMS = 2000;
   localparam int PHASE_LEN    = 80;     // items per random operation mix
   localparam int MAX_WAIT     = 18;     // longest idle/stall drawn per transaction
   localparam int IDLE_LIMIT   = 400;    // cycles without any transaction before giving up
   localparam int TAIL_CYCLES  = 20;     // quiet time after the last response
   localparam int REPORT_MAX   = 10;

   localparam logic [4:0] NIL       = 5'(LIST_DEPTH);
   localparam logic [3:0] FN_UNUSED = 4'd15;   // top of the undecoded code range

   // expected results that can be read off directly
   localparam rsp_type NO_NODE_EMPTY = '{data_out: 32'd0, has_value: 1'b0,
                                         pool_full: 1'b0, list_empty: 1'b1};
   localparam rsp_type PUSHED        = '{data_out: 32'd0, has_value: 1'b0,
                                         pool_full: 1'b0, list_empty: 1'b0};
   localparam rsp_type POOL_DROPPED  = '{data_out: 32'd0, has_value: 1'b0,
                                         pool_full: 1'b1, list_empty: 1'b0};

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_WALK, MIX_EVEN} mix_type;

   // one line of the directed script; reps > 1 repeats the operation
   typedef struct packed {
      logic [3:0]  func;
      logic [31:0] data;
      logic [4:0]  reps;
      logic        rand_data;
      logic        typed;
      rsp_type     want;
   } script_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_item;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_item;

   doubly_linked_list_cursor #(
      .DEPTH      (LIST_DEPTH),
      .DATA_WIDTH (32)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Predictor: a private copy of the node pool, links, free chain and cursor.
   // ---------------------------------------------------------------------------
   logic [31:0] pool_data [LIST_DEPTH];
   logic [4:0]  pool_next [LIST_DEPTH];
   logic [4:0]  pool_prev [LIST_DEPTH];
   logic [4:0]  head_node, tail_node, cursor_node, free_node;
   int          live_count;

   rsp_type        pending_rsp [$];   // results still owed by the block, oldest first
   rsp_type        want_rsp;
   int             fail_count;
   script_row_type script [$];
   bit             req_burst, rsp_burst;

   function automatic bit is_link(logic [4:0] p);
      return p < NIL;
   endfunction

   // pool as after reset or clean: free chain 0 -> 1 -> ... -> null
   function automatic void wipe_pool();
      for (int i = 0; i < LIST_DEPTH; i++) begin
         pool_next[i] = 5'(i + 1);
         pool_prev[i] = '0;
         pool_data[i] = '0;
      end
      free_node   = '0;
      head_node   = NIL;
      tail_node   = NIL;
      cursor_node = NIL;
      live_count  = 0;
   endfunction

   function automatic void link_front(logic [4:0] n);
      if (!is_link(head_node)) begin
         head_node = n;
         tail_node = n;
      end else begin
         pool_next[n]         = head_node;
         pool_prev[head_node] = n;
         head_node            = n;
      end
   endfunction

   // null cursor means the node goes to the front
   function automatic void link_after_cursor(logic [4:0] n);
      logic [4:0] succ;
      if (!is_link(cursor_node)) begin
         link_front(n);
         return;
      end
      succ         = pool_next[cursor_node];
      pool_next[n] = succ;
      pool_prev[n] = cursor_node;
      if (is_link(succ))
         pool_prev[succ] = n;
      else
         tail_node = n;
      pool_next[cursor_node] = n;
   endfunction

   // removes the cursor node, cursor moves to its successor, node returns to free chain
   function automatic bit unlink_cursor(output logic [31:0] value);
      logic [4:0] c, pred, succ;
      c     = cursor_node;
      value = '0;
      if (!is_link(c))
         return 1'b0;
      value = pool_data[c];
      pred  = pool_prev[c];
      succ  = pool_next[c];
      if (is_link(pred))
         pool_next[pred] = succ;
      else
         head_node = succ;
      if (is_link(succ))
         pool_prev[succ] = pred;
      else
         tail_node = pred;
      cursor_node  = succ;
      pool_next[c] = free_node;
      free_node    = c;
      if (live_count > 0)
         live_count--;
      return 1'b1;
   endfunction

   function automatic rsp_type list_step(req_type r);
      rsp_type     res;
      logic [4:0]  target, n;
      logic [31:0] popped;
      res = '0;
      case (r.func)
         FN_FIRST, FN_LAST: begin
            target = (r.func == FN_FIRST) ? head_node : tail_node;
            if (is_link(target)) begin
               cursor_node   = target;
               res.data_out  = pool_data[target];
               res.has_value = 1'b1;
            end
         end
         FN_NEXT, FN_PREV: begin
            if (is_link(cursor_node)) begin
               target = (r.func == FN_NEXT) ? pool_next[cursor_node] : pool_prev[cursor_node];
               if (is_link(target)) begin
                  cursor_node   = target;
                  res.data_out  = pool_data[target];
                  res.has_value = 1'b1;
               end
            end
         end
         FN_PUSH_FRONT, FN_PUSH_BACK, FN_PUSH_CURRENT: begin
            n = free_node;
            if (!is_link(n)) begin
               // pool exhausted: the push is dropped, cursor untouched
               res.pool_full = 1'b1;
            end else begin
               free_node    = pool_next[n];
               pool_data[n] = r.data_in;
               pool_next[n] = NIL;
               pool_prev[n] = NIL;
               live_count++;
               if (r.func == FN_PUSH_FRONT || (r.func == FN_PUSH_BACK && !is_link(tail_node)))
                  link_front(n);
               else begin
                  // push_back parks the cursor on the old tail first
                  if (r.func == FN_PUSH_BACK)
                     cursor_node = tail_node;
                  link_after_cursor(n);
               end
            end
         end
         FN_POP_FRONT, FN_POP_BACK, FN_POP_CURRENT: begin
            if (r.func == FN_POP_FRONT)
               cursor_node = head_node;
            else if (r.func == FN_POP_BACK)
               cursor_node = tail_node;
            res.has_value = unlink_cursor(popped);
            res.data_out  = popped;
         end
         FN_CLEAN: wipe_pool();
         default: ;
      endcase
      res.list_empty = (live_count == 0);
      return res;
   endfunction

   function automatic int draw_wait(bit burst);
      return burst ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // mostly random words, with the all-zero and all-one extremes mixed in
   function automatic logic [31:0] rand_word();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0)
         return '0;
      if (roll == 1)
         return '1;
      return $urandom;
   endfunction

   // ---------------------------------------------------------------------------
   // Request side. Entered just after a falling edge; returns at the falling edge
   // after acceptance, leaving req_valid for the next call (or the end) to set.
   // ---------------------------------------------------------------------------
   task automatic send_op(input req_type r, input bit typed, input rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = draw_wait(req_burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= r;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      // transaction accepted at this edge: advance the model now
      predicted = list_step(r);
      pending_rsp.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Response side: stall a random number of cycles per transaction, with runs
   // of zero-stall bursts so back-to-back responses are also exercised.
   // ---------------------------------------------------------------------------
   initial begin
      int stall_cycles;
      int taken;
      rsp_stall = 1'b0;
      taken     = 0;
      rsp_burst = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (taken % 50 == 0)
            rsp_burst = ($urandom_range(0, 3) == 0);
         stall_cycles = draw_wait(rsp_burst);
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid)
            @(posedge clock);
         taken++;
         @(negedge clock);
      end
   end

   // Checker: every accepted response is matched against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
               $display("%0t: unexpected response: data %h has %b full %b empty %b",
                        $realtime, rsp_item.data_out, rsp_item.has_value,
                        rsp_item.pool_full, rsp_item.list_empty);
         end else begin
            want_rsp = pending_rsp.pop_front();
            if (rsp_item.data_out !== want_rsp.data_out ||
                rsp_item.has_value !== want_rsp.has_value ||
                rsp_item.pool_full !== want_rsp.pool_full ||
                rsp_item.list_empty !== want_rsp.list_empty) begin
               fail_count++;
               if (fail_count <= REPORT_MAX) begin
                  $display("%0t: mismatch: expected data %h has %b full %b empty %b",
                           $realtime, want_rsp.data_out, want_rsp.has_value,
                           want_rsp.pool_full, want_rsp.list_empty);
                  $display("   got data %h has %b full %b empty %b",
                           rsp_item.data_out, rsp_item.has_value,
                           rsp_item.pool_full, rsp_item.list_empty);
               end
            end
         end
      end
   end

   // Watchdog: a long run of cycles with no transaction on either side is a hang.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Main sequence: reset, directed script, random mixes, drain, verdict.
   // ---------------------------------------------------------------------------
   initial begin
      req_type        op;
      script_row_type row;
      mix_type        mix;
      int             roll, push_pct, pop_pct;

      reset      = 1'b1;
      req_valid  = 1'b0;
      req_item   = '0;
      fail_count = 0;
      req_burst  = 1'b0;
      mix        = MIX_EVEN;
      wipe_pool();

      // Empty list: every lookup and pop comes back with nothing.
      script.push_back('{FN_FIRST,        32'h0,         5'd1,  1'b0, 1'b1, NO_NODE_EMPTY});
      script.push_back('{FN_NEXT,         32'h0,         5'd1,  1'b0, 1'b1, NO_NODE_EMPTY});
      script.push_back('{FN_POP_BACK,     32'h0,         5'd1,  1'b0, 1'b1, NO_NODE_EMPTY});
      script.push_back('{FN_POP_CURRENT,  32'h0,         5'd1,  1'b0, 1'b1, NO_NODE_EMPTY});
      script.push_back('{FN_UNUSED,       32'hFFFF_FFFF, 5'd1,  1'b0, 1'b1, NO_NODE_EMPTY});
      // Null cursor: push_current lands at the front; then fill the pool.
      script.push_back('{FN_PUSH_CURRENT, 32'h0,         5'd1,  1'b0, 1'b1, PUSHED});
      script.push_back('{FN_PUSH_BACK,    32'hFFFF_FFFF, 5'd1,  1'b0, 1'b0, PUSHED});
      script.push_back('{FN_PUSH_FRONT,   32'h0,         5'd14, 1'b1, 1'b0, PUSHED});
      // Pool full: push dropped, flag raised, list untouched.
      script.push_back('{FN_PUSH_BACK,    32'h8000_0001, 5'd1,  1'b0, 1'b1, POOL_DROPPED});
      // Walk the cursor to the tail end and try to step past it, then pop at the cursor and the front.
      script.push_back('{FN_LAST,         32'h0,         5'd1,  1'b0, 1'b0, PUSHED});
      script.push_back('{FN_PREV,         32'h0,         5'd1,  1'b0, 1'b0, PUSHED});
      script.push_back('{FN_NEXT,         32'h0,         5'd1,  1'b0, 1'b0, PUSHED});
      script.push_back('{FN_NEXT,         32'h0,         5'd1,  1'b0, 1'b0, PUSHED});
      script.push_back('{FN_POP_CURRENT,  32'h0,         5'd1,  1'b0, 1'b0, PUSHED});
      script.push_back('{FN_POP_FRONT,    32'h0,         5'd1,  1'b0, 1'b0, PUSHED});
      // Clean empties everything; a later lookup finds nothing.
      script.push_back('{FN_CLEAN,        32'h0,         5'd1,  1'b0, 1'b1, NO_NODE_EMPTY});
      script.push_back('{FN_LAST,         32'h0,         5'd1,  1'b0, 1'b1, NO_NODE_EMPTY});

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         row = script[i];
         for (int k = 0; k < row.reps; k++) begin
            op.func    = row.func;
            op.data_in = row.rand_data ? rand_word() : row.data;
            send_op(op, row.typed, row.want);
         end
      end

      // Random part: phases bias toward filling, draining, walking or an even mix,
      // so full-pool and empty-list corners keep recurring with live data.
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % PHASE_LEN == 0) begin
            mix       = mix_type'($urandom_range(0, 3));
            req_burst = ($urandom_range(0, 3) == 0);
         end
         case (mix)
            MIX_FILL:  begin push_pct = 60; pop_pct = 15; end
            MIX_DRAIN: begin push_pct = 15; pop_pct = 60; end
            MIX_WALK:  begin push_pct = 15; pop_pct = 15; end
            default:   begin push_pct = 35; pop_pct = 30; end
         endcase
         roll = $urandom_range(0, 99);
         if (roll == 0)
            op.func = FN_CLEAN;
         else if (roll == 1)
            op.func = 4'($urandom_range(FN_CLEAN + 1, FN_UNUSED));
         else if (roll < 2 + push_pct)
            op.func = 4'(FN_PUSH_FRONT + $urandom_range(0, 2));
         else if (roll < 2 + push_pct + pop_pct)
            op.func = 4'(FN_POP_FRONT + $urandom_range(0, 2));
         else
            op.func = 4'(FN_FIRST + $urandom_range(0, 3));
         op.data_in = rand_word();
         send_op(op, 1'b0, PUSHED);
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/dllc_pkg.sv
rtl/doubly_linked_list_cursor.sv
tb/tb_top.sv
